### sv/euler_to_quaternion_assert.svh
// ----------------------------------------------------------------------------
// Euler to quaternion assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// Consequence in the same cycle as the antecedent.
`define E2Q_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("euler_to_quaternion: same-cycle property failed");

// Consequence in the cycle after the antecedent.
`define E2Q_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("euler_to_quaternion: next-cycle property failed");

`endif

### sv/e2q_pkg.sv
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Shared widths, turn constants, arctangent table and CORDIC lane type.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_STAGES = 32;
	localparam int ANGLE_W = 16;
	localparam int QUAT_W = 16;
	localparam int CW = 34;
	localparam int MAG_W = 14;
	localparam int AXES = 3;
	localparam int PREP_STAGES = 4;
	localparam int MUL_STAGES = 6;

	localparam longint unsigned HALF_TURN = 64'd23040;
	localparam int FULL_TURN = 46080;
	localparam int QUARTER_TURN = 11520;
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam int DIV45 = 45;
	localparam int RECIP45 = 23302;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic neg;
	} e2q_rot_t;

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'd843314856;
			1: v = 32'd497837829;
			2: v = 32'd263043836;
			3: v = 32'd133525158;
			4: v = 32'd67021686;
			5: v = 32'd33543515;
			6: v = 32'd16775850;
			7: v = 32'd8388437;
			8: v = 32'd4194282;
			9: v = 32'd2097149;
			10: v = 32'd1048575;
			11: v = 32'd524287;
			12: v = 32'd262143;
			13: v = 32'd131071;
			14: v = 32'd65535;
			15: v = 32'd32767;
			16: v = 32'd16383;
			17: v = 32'd8191;
			18: v = 32'd4095;
			19: v = 32'd2047;
			20: v = 32'd1023;
			21: v = 32'd511;
			22: v = 32'd255;
			23: v = 32'd127;
			24: v = 32'd63;
			25: v = 32'd31;
			26: v = 32'd15;
			27: v = 32'd7;
			28: v = 32'd3;
			29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// Whole half turns in r*pi*2^30, evaluated only for elaboration constants.
	function automatic logic [22:0] rad_quot(input int r);
		logic [63:0] p;
		p = 64'(r) * PI_Q30;
		return 23'(p / HALF_TURN);
	endfunction

	function automatic logic [14:0] rad_rem(input int r);
		logic [63:0] p;
		p = 64'(r) * PI_Q30;
		return 15'(p % HALF_TURN);
	endfunction

endpackage

### sv/e2q_angle_prep.sv
// ----------------------------------------------------------------------------
// Angle preparation
// Folds each half angle into a quarter turn and converts it to Q.30 radians.
// ----------------------------------------------------------------------------
module e2q_angle_prep import e2q_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [ANGLE_W-1:0] ang [AXES],
	output e2q_rot_t                  rot [AXES]
);

	logic [22:0] quot_tab [0:DIV45-1];
	logic [14:0] rem_tab [0:DIV45-1];

	for (genvar g = 0; g < DIV45; g++) begin : g_tab
		localparam logic [22:0] QV = rad_quot(g);
		localparam logic [14:0] RV = rad_rem(g);
		assign quot_tab[g] = QV;
		assign rem_tab[g] = RV;
	end

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic signed [16:0] u;
		logic fold;
		logic [MAG_W-1:0] mag_s1, mag_s2;
		logic sgn_s1, sgn_s2, sgn_s3, neg_s1, neg_s2, neg_s3;
		logic [28:0] recip_prod;
		logic [8:0] h_s2;
		logic [40:0] t_s3;
		logic [5:0] r_s3;
		logic [16:0] rest;
		logic [31:0] q;
		e2q_rot_t rot_s4;

		// Wrap into a half turn either way, then fold into a quarter turn.
		always_comb begin
			u = 17'(ang[a]);
			fold = 1'b0;
			if (u >= 17'sd23040) begin
				u = u - 17'sd46080;
			end
			if (u < -17'sd23040) begin
				u = u + 17'sd46080;
			end
			if (u > 17'sd11520) begin
				u = u - 17'sd23040;
				fold = 1'b1;
			end
			if (u < -17'sd11520) begin
				u = u + 17'sd23040;
				fold = 1'b1;
			end
		end

		assign recip_prod = 29'(mag_s1) * 29'(RECIP45);

		// Magnitude split as 45*h + r; h*pi is exact and r*pi comes from the table.
		assign rest = 17'(9'(t_s3[8:0]) * 17'(DIV45)) + 17'(rem_tab[r_s3])
			+ 17'(QUARTER_TURN);

		always_comb begin
			q = 32'(t_s3[40:9]) + 32'(quot_tab[r_s3]);
			if (rest >= 17'(FULL_TURN)) begin
				q = q + 32'd2;
			end else if (rest >= 17'(HALF_TURN)) begin
				q = q + 32'd1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s1 <= MAG_W'(u < 0 ? -u : u);
				sgn_s1 <= u[16];
				neg_s1 <= fold;
				h_s2 <= recip_prod[28:20];
				mag_s2 <= mag_s1;
				sgn_s2 <= sgn_s1;
				neg_s2 <= neg_s1;
				r_s3 <= 6'(mag_s2 - MAG_W'(h_s2 * 14'(DIV45)));
				t_s3 <= 41'(h_s2) * 41'(PI_Q30);
				sgn_s3 <= sgn_s2;
				neg_s3 <= neg_s2;
				rot_s4.x <= CW'(GAIN_Q30);
				rot_s4.y <= '0;
				rot_s4.z <= sgn_s3 ? -CW'(q) : CW'(q);
				rot_s4.neg <= neg_s3;
			end
		end

		assign rot[a] = rot_s4;
	end

endmodule

### sv/e2q_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation for all three axes, registered.
// ----------------------------------------------------------------------------
module e2q_cordic_cell import e2q_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic     clk,
	input  logic     en,
	input  e2q_rot_t cur [AXES],
	output e2q_rot_t nxt [AXES]
);

	localparam logic signed [CW-1:0] ANGLE = CW'(atan_q30(STAGE));

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic signed [CW-1:0] dx, dy;
		e2q_rot_t rot_q;

		assign dx = cur[a].y >>> STAGE;
		assign dy = cur[a].x >>> STAGE;

		always_ff @(posedge clk) begin
			if (en) begin
				rot_q.neg <= cur[a].neg;
				if (!cur[a].z[CW-1]) begin
					rot_q.x <= cur[a].x - dx;
					rot_q.y <= cur[a].y + dy;
					rot_q.z <= cur[a].z - ANGLE;
				end else begin
					rot_q.x <= cur[a].x + dx;
					rot_q.y <= cur[a].y - dy;
					rot_q.z <= cur[a].z + ANGLE;
				end
			end
		end

		assign nxt[a] = rot_q;
	end

endmodule

### sv/e2q_quat_mul.sv
// ----------------------------------------------------------------------------
// Quaternion product
// Forms (qx*qy)*qz from the axis cosines and sines, rounds to Q1.14.
// ----------------------------------------------------------------------------
module e2q_quat_mul import e2q_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  e2q_rot_t                 rot [AXES],
	output logic signed [QUAT_W-1:0] quat_w,
	output logic signed [QUAT_W-1:0] quat_x,
	output logic signed [QUAT_W-1:0] quat_y,
	output logic signed [QUAT_W-1:0] quat_z
);

	localparam logic signed [63:0] RND30 = 64'sd536870912;
	localparam logic signed [34:0] RND16 = 35'sd32768;

	logic signed [31:0] c_s1 [AXES];
	logic signed [31:0] s_s1 [AXES];
	logic signed [63:0] pw_s2, px_s2, py_s2, pz_s2;
	logic signed [31:0] cz_s2, sz_s2, cz_s3, sz_s3;
	logic signed [31:0] aw_s3, ax_s3, ay_s3, az_s3;
	logic signed [63:0] m_s4 [8];
	logic signed [34:0] r_s5 [4];
	logic signed [QUAT_W-1:0] o_s6 [4];
	logic signed [64:0] sum [4];

	// Sum pairs of the second product, then round from Q.60 back to Q.30.
	always_comb begin
		sum[0] = 65'(m_s4[0]) - 65'(m_s4[1]) + 65'(RND30);
		sum[1] = 65'(m_s4[2]) + 65'(m_s4[3]) + 65'(RND30);
		sum[2] = 65'(m_s4[4]) - 65'(m_s4[5]) + 65'(RND30);
		sum[3] = 65'(m_s4[6]) + 65'(m_s4[7]) + 65'(RND30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				c_s1[a] <= 32'(rot[a].neg ? -rot[a].x : rot[a].x);
				s_s1[a] <= 32'(rot[a].neg ? -rot[a].y : rot[a].y);
			end
			// qx*qy has one nonzero term per component.
			pw_s2 <= c_s1[0] * c_s1[1];
			px_s2 <= s_s1[0] * c_s1[1];
			py_s2 <= c_s1[0] * s_s1[1];
			pz_s2 <= s_s1[0] * s_s1[1];
			cz_s2 <= c_s1[2];
			sz_s2 <= s_s1[2];
			aw_s3 <= 32'((pw_s2 + RND30) >>> 30);
			ax_s3 <= 32'((px_s2 + RND30) >>> 30);
			ay_s3 <= 32'((py_s2 + RND30) >>> 30);
			az_s3 <= 32'((pz_s2 + RND30) >>> 30);
			cz_s3 <= cz_s2;
			sz_s3 <= sz_s2;
			m_s4[0] <= aw_s3 * cz_s3;
			m_s4[1] <= az_s3 * sz_s3;
			m_s4[2] <= ax_s3 * cz_s3;
			m_s4[3] <= ay_s3 * sz_s3;
			m_s4[4] <= ay_s3 * cz_s3;
			m_s4[5] <= ax_s3 * sz_s3;
			m_s4[6] <= aw_s3 * sz_s3;
			m_s4[7] <= az_s3 * cz_s3;
			for (int k = 0; k < 4; k++) begin
				r_s5[k] <= 35'(sum[k] >>> 30);
			end
			for (int k = 0; k < 4; k++) begin
				o_s6[k] <= sat_q14(r_s5[k]);
			end
		end
	end

	function automatic logic signed [QUAT_W-1:0] sat_q14(input logic signed [34:0] v);
		logic signed [18:0] t;
		t = 19'((v + RND16) >>> 16);
		if (t > 19'sd32767) begin
			return 16'sh7fff;
		end else if (t < -19'sd32768) begin
			return 16'sh8000;
		end
		return t[15:0];
	endfunction

	assign quat_w = o_s6[0];
	assign quat_x = o_s6[1];
	assign quat_y = o_s6[2];
	assign quat_z = o_s6[3];

endmodule

### sv/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// Euler to quaternion, XYZ order
// Converts three half angles to cosine/sine pairs with an unrolled CORDIC
// chain and multiplies the axis quaternions into one rotation quaternion.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   angle_x, angle_y, angle_z (deg, 6 frac bits)
//   output    out_valid / out_ready quat_w, quat_x, quat_y, quat_z (Q1.14)
//
// One item is taken every cycle while in_ready is high. An item passes
// through the radian conversion stages, one CORDIC cell per stage and the
// two quaternion products on its way to the output register. Reset clears
// only the valid bits and the output flags. A stalled output fills a
// one-entry skid register; while it is full the whole pipeline holds and
// in_ready is low.
//
module euler_to_quaternion import e2q_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [ANGLE_W-1:0] angle_x,
	input  logic signed [ANGLE_W-1:0] angle_y,
	input  logic signed [ANGLE_W-1:0] angle_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [QUAT_W-1:0]  quat_w,
	output logic signed [QUAT_W-1:0]  quat_x,
	output logic signed [QUAT_W-1:0]  quat_y,
	output logic signed [QUAT_W-1:0]  quat_z
);

	// Stages beyond the table length would only repeat zero angles.
	localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
	localparam int LAT = PREP_STAGES + NS + MUL_STAGES;

	logic en;
	logic [LAT-1:0] vld_q;
	logic signed [ANGLE_W-1:0] ang [AXES];
	e2q_rot_t chain [NS+1][AXES];
	logic signed [QUAT_W-1:0] pw, px, py, pz;

	// The pipeline advances whenever the skid register is free.
	assign en = in_ready;

	assign ang[0] = angle_x;
	assign ang[1] = angle_y;
	assign ang[2] = angle_z;

	e2q_angle_prep u_prep (
		.clk (clk),
		.en  (en),
		.ang (ang),
		.rot (chain[0])
	);

	for (genvar i = 0; i < NS; i++) begin : g_cell
		e2q_cordic_cell #(.STAGE(i)) u_cell (
			.clk (clk),
			.en  (en),
			.cur (chain[i]),
			.nxt (chain[i+1])
		);
	end

	e2q_quat_mul u_mul (
		.clk    (clk),
		.en     (en),
		.rot    (chain[NS]),
		.quat_w (pw),
		.quat_x (px),
		.quat_y (py),
		.quat_z (pz)
	);

	// Valid bits travel beside the data and stall with it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Output register with a one-entry skid behind it.
	logic out_q, skid_q, push, take;
	logic signed [QUAT_W-1:0] ow_q, ox_q, oy_q, oz_q;
	logic signed [QUAT_W-1:0] sw_q, sx_q, sy_q, sz_q;

	assign push = vld_q[LAT-1] & ~skid_q;
	assign take = out_q & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= 1'b0;
			skid_q <= 1'b0;
		end else if (!out_q || take) begin
			out_q <= skid_q | push;
			skid_q <= 1'b0;
		end else if (push) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_q || take) begin
			if (skid_q) begin
				ow_q <= sw_q;
				ox_q <= sx_q;
				oy_q <= sy_q;
				oz_q <= sz_q;
			end else begin
				ow_q <= pw;
				ox_q <= px;
				oy_q <= py;
				oz_q <= pz;
			end
		end else if (push) begin
			sw_q <= pw;
			sx_q <= px;
			sy_q <= py;
			sz_q <= pz;
		end
	end

	assign in_ready = ~skid_q;
	assign out_valid = out_q;
	assign quat_w = ow_q;
	assign quat_x = ox_q;
	assign quat_y = oy_q;
	assign quat_z = oz_q;

endmodule

### sv/euler_to_quaternion_chk.sv
// ----------------------------------------------------------------------------
// Euler to quaternion port checker
// Watches the top level's ports for stall and backpressure behavior.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_assert.svh"

module euler_to_quaternion_chk import e2q_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [QUAT_W-1:0]  quat_w,
	input logic signed [QUAT_W-1:0]  quat_x,
	input logic signed [QUAT_W-1:0]  quat_y,
	input logic signed [QUAT_W-1:0]  quat_z
);

	// A stalled result holds its value.
	`E2Q_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(quat_w) && $stable(quat_x) && $stable(quat_y) && $stable(quat_z))

	// Input backpressure only ever comes from a waiting result.
	`E2Q_ASSERT_NOW(a_ready_cause, !in_ready, out_valid)

	// Without an output handshake the backpressure cannot clear.
	`E2Q_ASSERT_NEXT(a_ready_stays, !in_ready && !out_ready, !in_ready)

	// Once the output is taken the input side is free again.
	`E2Q_ASSERT_NEXT(a_ready_frees, out_valid && out_ready, in_ready)

endmodule

bind euler_to_quaternion euler_to_quaternion_chk u_chk (.*);
